[hdl/min_conflict_queens_step_defines.svh]
// Assertion macros for the min-conflicts queens step block.
`ifndef MIN_CONFLICT_QUEENS_STEP_DEFINES_SVH
`define MIN_CONFLICT_QUEENS_STEP_DEFINES_SVH
`ifndef ASSERT_OFF
// General property, checked on every rising edge outside reset.
`define MCQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Overlapping implication, checked on every rising edge outside reset.
`define MCQ_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`else
`define MCQ_ASSERT(lbl, prop, msg)
`define MCQ_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

[hdl/mcq_pkg.sv]
// Shared types, constants and count helpers for the min-conflicts queens step block.
package mcq_pkg;

	localparam int BOARD_SIZE_DEF = 32;
	localparam int FIELD_W = 5;
	localparam int CNT_W = 6;
	localparam int SCORE_W = CNT_W + 3;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;
	localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

	typedef enum logic [1:0] {
		FUNC_LOAD   = 2'd0,
		FUNC_ADJUST = 2'd1,
		FUNC_READ   = 2'd2,
		FUNC_NOP    = 2'd3
	} func_t;

	typedef struct packed {
		func_t              func;
		logic [FIELD_W-1:0] row_index;
		logic [FIELD_W-1:0] column_in;
	} cmd_t;

	typedef struct packed {
		logic [FIELD_W-1:0] column_out;
		logic               moved;
		logic               solved;
	} rsp_t;

	// Column, main diagonal and anti-diagonal counts of one square.
	typedef struct packed {
		logic [CNT_W-1:0] col;
		logic [CNT_W-1:0] main;
		logic [CNT_W-1:0] anti;
	} cnt_trio_t;

	function automatic logic [CNT_W-1:0] cnt_inc(input logic [CNT_W-1:0] v);
		return (v == CNT_MAX) ? v : v + CNT_W'(1);
	endfunction

	function automatic logic [CNT_W-1:0] cnt_dec(input logic [CNT_W-1:0] v);
		return (v == '0) ? v : v - CNT_W'(1);
	endfunction

	function automatic cnt_trio_t trio_inc(input cnt_trio_t t);
		cnt_trio_t r;
		r.col  = cnt_inc(t.col);
		r.main = cnt_inc(t.main);
		r.anti = cnt_inc(t.anti);
		return r;
	endfunction

	function automatic cnt_trio_t trio_dec(input cnt_trio_t t);
		cnt_trio_t r;
		r.col  = cnt_dec(t.col);
		r.main = cnt_dec(t.main);
		r.anti = cnt_dec(t.anti);
		return r;
	endfunction

	function automatic logic trio_all_one(input cnt_trio_t t);
		return (t.col == CNT_ONE) && (t.main == CNT_ONE) && (t.anti == CNT_ONE);
	endfunction

endpackage

[hdl/mcq_count_bank.sv]
// Column, main diagonal and anti-diagonal count memories with a shared square address.
module mcq_count_bank #(
	parameter int BOARD_SIZE = mcq_pkg::BOARD_SIZE_DEF,
	localparam int CW = $clog2(BOARD_SIZE),
	localparam int DIAG = 2 * BOARD_SIZE - 1,
	localparam int DW = $clog2(DIAG)
) (
	input  logic               clk,
	input  logic [CW-1:0]      rd_row,
	input  logic [CW-1:0]      rd_col,
	output mcq_pkg::cnt_trio_t rd_cnt,
	input  logic               wr_en,
	input  logic [CW-1:0]      wr_row,
	input  logic [CW-1:0]      wr_col,
	input  mcq_pkg::cnt_trio_t wr_cnt,
	input  logic               clr_en,
	input  logic [DW-1:0]      clr_idx
);
	import mcq_pkg::*;

	localparam logic [DW-1:0] MAIN_OFS = DW'(BOARD_SIZE - 1);
	localparam logic [DW-1:0] COL_DEPTH = DW'(BOARD_SIZE);

	logic [CNT_W-1:0] col_mem  [BOARD_SIZE];
	logic [CNT_W-1:0] main_mem [DIAG];
	logic [CNT_W-1:0] anti_mem [DIAG];

	logic [CNT_W-1:0] col_rd_q, main_rd_q, anti_rd_q;
	logic             col_we, dg_we;
	logic [CW-1:0]    col_wa;
	logic [DW-1:0]    main_wa, anti_wa, main_ra, anti_ra;
	logic [CNT_W-1:0] col_wd, main_wd, anti_wd;

	function automatic logic [DW-1:0] main_idx(input logic [CW-1:0] r, input logic [CW-1:0] c);
		return DW'(r) + MAIN_OFS - DW'(c);
	endfunction

	function automatic logic [DW-1:0] anti_idx(input logic [CW-1:0] r, input logic [CW-1:0] c);
		return DW'(r) + DW'(c);
	endfunction

	assign main_ra = main_idx(rd_row, rd_col);
	assign anti_ra = anti_idx(rd_row, rd_col);

	always_comb begin
		col_we  = 1'b0;
		dg_we   = 1'b0;
		col_wa  = wr_col;
		col_wd  = wr_cnt.col;
		main_wa = main_idx(wr_row, wr_col);
		anti_wa = anti_idx(wr_row, wr_col);
		main_wd = wr_cnt.main;
		anti_wd = wr_cnt.anti;
		if (clr_en) begin
			col_we  = (clr_idx < COL_DEPTH);
			dg_we   = 1'b1;
			col_wa  = CW'(clr_idx);
			col_wd  = '0;
			main_wa = clr_idx;
			anti_wa = clr_idx;
			main_wd = '0;
			anti_wd = '0;
		end else if (wr_en) begin
			col_we = 1'b1;
			dg_we  = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (col_we) begin
			col_mem[col_wa] <= col_wd;
		end
		col_rd_q <= col_mem[rd_col];
	end

	always_ff @(posedge clk) begin
		if (dg_we) begin
			main_mem[main_wa] <= main_wd;
		end
		main_rd_q <= main_mem[main_ra];
	end

	always_ff @(posedge clk) begin
		if (dg_we) begin
			anti_mem[anti_wa] <= anti_wd;
		end
		anti_rd_q <= anti_mem[anti_ra];
	end

	assign rd_cnt = '{col: col_rd_q, main: main_rd_q, anti: anti_rd_q};

endmodule

[hdl/min_conflict_queens_step.sv]
// Top level of the min-conflicts N queens step engine.
//
// Channel   Direction  Handshake                       Payload
// command   in         start high while busy is low    cmd    (func, row_index, column_in)
// result    out        done high for one cycle         result (column_out, moved, solved)
//
// Each count memory and the queen memory has a single read port: the scan and
// the check visit one column or row per cycle. After reset a clearing pass
// zeroes the counts, with busy high. The result receiver cannot stall; a new
// item may be accepted in the same cycle that the previous result is shown.
`include "min_conflict_queens_step_defines.svh"
module min_conflict_queens_step #(
	parameter int BOARD_SIZE = mcq_pkg::BOARD_SIZE_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  mcq_pkg::cmd_t cmd,
	output logic          busy,
	output logic          done,
	output mcq_pkg::rsp_t result
);
	import mcq_pkg::*;

	localparam int CW = $clog2(BOARD_SIZE);
	localparam int DIAG = 2 * BOARD_SIZE - 1;
	localparam int DW = $clog2(DIAG);
	localparam logic [CW-1:0] LAST_IDX = CW'(BOARD_SIZE - 1);
	localparam logic [DW-1:0] LAST_CLR = DW'(DIAG - 1);

	// One-hot sequencer states.
	typedef enum logic [12:0] {
		S_CLEAR     = 13'h0001,
		S_IDLE      = 13'h0002,
		S_LD_RD     = 13'h0004,
		S_LD_WR     = 13'h0008,
		S_Q_RD      = 13'h0010,
		S_Q_USE     = 13'h0020,
		S_AD_SCAN   = 13'h0040,
		S_AD_LAST   = 13'h0080,
		S_LIFT_RD   = 13'h0100,
		S_LIFT_WR   = 13'h0200,
		S_PLACE_WR  = 13'h0400,
		S_CHK       = 13'h0800,
		S_CHK_FLUSH = 13'h1000
	} state_t;

	state_t state_q;

	logic [DW-1:0] clr_q;
	func_t         func_q;
	logic [CW-1:0] row_q, cin_q, cur_q, best_q, col_q;
	logic [CW-1:0] scan_q, col_s1;
	logic [CW-1:0] chk_row_q, chk_row_s1;
	logic          cmp_v_s1, chk_v_s1, chk_v_s2;
	logic          moved_q, cur_one_q, all_ok_q;
	logic          done_q;
	rsp_t          result_q;

	logic signed [SCORE_W-1:0] best_score_q;

	// Queen column memory: one entry per row, undefined until loaded.
	logic [CW-1:0] queen_mem [BOARD_SIZE];
	logic [CW-1:0] q_rdata_q;
	logic          q_we;
	logic [CW-1:0] q_wa, q_ra, q_wd;

	// Count bank access.
	cnt_trio_t     cnt_rd, cnt_wd, cnt_inc_v, cnt_dec_v;
	logic [CW-1:0] cnt_rd_row, cnt_rd_col, cnt_wr_col;
	logic          cnt_we;

	// Shared scoring unit: one three-input add and one signed compare.
	logic signed [SCORE_W-1:0] score_sum, cur_score;
	logic                      cand_better;
	logic [CW-1:0]             win_col;

	logic row_ok, col_ok;

	function automatic rsp_t make_rsp(input logic [CW-1:0] c, input logic m, input logic s);
		rsp_t r;
		r.column_out = FIELD_W'(c);
		r.moved      = m;
		r.solved     = s;
		return r;
	endfunction

	assign row_ok = 32'(cmd.row_index) < 32'(BOARD_SIZE);
	assign col_ok = 32'(cmd.column_in) < 32'(BOARD_SIZE);

	assign cnt_inc_v = trio_inc(cnt_rd);
	assign cnt_dec_v = trio_dec(cnt_rd);

	assign score_sum = $signed(SCORE_W'(cnt_rd.col)) + $signed(SCORE_W'(cnt_rd.main))
		+ $signed(SCORE_W'(cnt_rd.anti));
	// The current square counts its own queen on both diagonals, so those two
	// contributions are taken off.
	assign cur_score = score_sum - $signed(SCORE_W'(2));
	assign cand_better = cmp_v_s1 && (col_s1 != cur_q) && (score_sum < best_score_q);
	assign win_col = cand_better ? col_s1 : best_q;

	// Memory addressing follows the sequencer state.
	always_comb begin
		q_ra       = row_q;
		q_we       = 1'b0;
		q_wa       = row_q;
		q_wd       = cin_q;
		cnt_rd_row = row_q;
		cnt_rd_col = cin_q;
		cnt_we     = 1'b0;
		cnt_wr_col = cin_q;
		cnt_wd     = cnt_inc_v;
		case (state_q)
			S_LD_RD: begin
				q_we = 1'b1;
			end
			S_LD_WR: begin
				cnt_we = 1'b1;
			end
			S_Q_USE: begin
				cnt_rd_col = q_rdata_q;
			end
			S_AD_SCAN: begin
				cnt_rd_col = scan_q;
			end
			S_LIFT_RD: begin
				cnt_rd_col = cur_q;
			end
			S_LIFT_WR: begin
				cnt_we     = 1'b1;
				cnt_wr_col = cur_q;
				cnt_wd     = cnt_dec_v;
				cnt_rd_col = best_q;
			end
			S_PLACE_WR: begin
				cnt_we     = 1'b1;
				cnt_wr_col = best_q;
				q_we       = 1'b1;
				q_wd       = best_q;
			end
			S_CHK: begin
				q_ra       = chk_row_q;
				cnt_rd_row = chk_row_s1;
				cnt_rd_col = q_rdata_q;
			end
			S_CHK_FLUSH: begin
				cnt_rd_row = chk_row_s1;
				cnt_rd_col = q_rdata_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_we) begin
			queen_mem[q_wa] <= q_wd;
		end
		q_rdata_q <= queen_mem[q_ra];
	end

	mcq_count_bank #(
		.BOARD_SIZE(BOARD_SIZE)
	) u_counts (
		.clk    (clk),
		.rd_row (cnt_rd_row),
		.rd_col (cnt_rd_col),
		.rd_cnt (cnt_rd),
		.wr_en  (cnt_we),
		.wr_row (row_q),
		.wr_col (cnt_wr_col),
		.wr_cnt (cnt_wd),
		.clr_en (state_q == S_CLEAR),
		.clr_idx(clr_q)
	);

	// Sequencer. Scan and check each run a short pipeline: the address is issued
	// in one cycle, the memory data is compared in the next (the check needs one
	// extra stage because the queen column addresses the counts).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_q        <= '0;
			func_q       <= FUNC_NOP;
			row_q        <= '0;
			cin_q        <= '0;
			cur_q        <= '0;
			best_q       <= '0;
			col_q        <= '0;
			scan_q       <= '0;
			col_s1       <= '0;
			chk_row_q    <= '0;
			chk_row_s1   <= '0;
			cmp_v_s1     <= 1'b0;
			chk_v_s1     <= 1'b0;
			chk_v_s2     <= 1'b0;
			moved_q      <= 1'b0;
			cur_one_q    <= 1'b0;
			all_ok_q     <= 1'b0;
			best_score_q <= '0;
			done_q       <= 1'b0;
			result_q     <= '0;
		end else begin
			done_q     <= 1'b0;
			cmp_v_s1   <= (state_q == S_AD_SCAN);
			col_s1     <= scan_q;
			chk_v_s1   <= (state_q == S_CHK);
			chk_row_s1 <= chk_row_q;
			chk_v_s2   <= chk_v_s1;
			if (chk_v_s2) begin
				all_ok_q <= all_ok_q & trio_all_one(cnt_rd);
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + DW'(1);
					if (clr_q == LAST_CLR) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						func_q <= cmd.func;
						row_q  <= CW'(cmd.row_index);
						cin_q  <= CW'(cmd.column_in);
						if (cmd.func == FUNC_NOP || !row_ok) begin
							// Nothing to do: an all-zero result goes out at once.
							done_q   <= 1'b1;
							result_q <= '0;
						end else if (cmd.func == FUNC_LOAD && col_ok) begin
							state_q <= S_LD_RD;
						end else begin
							state_q <= S_Q_RD;
						end
					end
				end
				S_LD_RD: begin
					state_q <= S_LD_WR;
				end
				S_LD_WR: begin
					done_q   <= 1'b1;
					result_q <= make_rsp(cin_q, 1'b0, 1'b0);
					state_q  <= S_IDLE;
				end
				S_Q_RD: begin
					state_q <= S_Q_USE;
				end
				S_Q_USE: begin
					cur_q   <= q_rdata_q;
					col_q   <= q_rdata_q;
					moved_q <= 1'b0;
					case (func_q)
						FUNC_ADJUST: begin
							scan_q  <= '0;
							state_q <= S_AD_SCAN;
						end
						FUNC_READ: begin
							all_ok_q  <= 1'b1;
							chk_row_q <= '0;
							state_q   <= S_CHK;
						end
						default: begin
							// Load with a column off the board: report the stored column.
							done_q   <= 1'b1;
							result_q <= make_rsp(q_rdata_q, 1'b0, 1'b0);
							state_q  <= S_IDLE;
						end
					endcase
				end
				S_AD_SCAN: begin
					if (!cmp_v_s1) begin
						// First cycle: the data are those of the current square.
						best_score_q <= cur_score;
						best_q       <= cur_q;
					end else if (cand_better) begin
						best_score_q <= score_sum;
						best_q       <= col_s1;
					end
					scan_q <= scan_q + CW'(1);
					if (scan_q == LAST_IDX) begin
						state_q <= S_AD_LAST;
					end
				end
				S_AD_LAST: begin
					best_q <= win_col;
					if (win_col != cur_q) begin
						state_q <= S_LIFT_RD;
					end else begin
						done_q   <= 1'b1;
						result_q <= make_rsp(cur_q, 1'b0, 1'b0);
						state_q  <= S_IDLE;
					end
				end
				S_LIFT_RD: begin
					state_q <= S_LIFT_WR;
				end
				S_LIFT_WR: begin
					cur_one_q <= (cnt_dec_v.col == CNT_ONE);
					state_q   <= S_PLACE_WR;
				end
				S_PLACE_WR: begin
					col_q   <= best_q;
					moved_q <= 1'b1;
					if (cur_one_q && trio_all_one(cnt_inc_v)) begin
						all_ok_q  <= 1'b1;
						chk_row_q <= '0;
						state_q   <= S_CHK;
					end else begin
						done_q   <= 1'b1;
						result_q <= make_rsp(best_q, 1'b1, 1'b0);
						state_q  <= S_IDLE;
					end
				end
				S_CHK: begin
					chk_row_q <= chk_row_q + CW'(1);
					if (chk_row_q == LAST_IDX) begin
						state_q <= S_CHK_FLUSH;
					end
				end
				S_CHK_FLUSH: begin
					if (!chk_v_s1) begin
						// The last row is being compared in this cycle.
						done_q   <= 1'b1;
						result_q <= make_rsp(col_q, moved_q, all_ok_q & trio_all_one(cnt_rd));
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;

	// A result only ever follows an accepted item or the end of a busy phase.
	`MCQ_ASSERT_IMP(a_done_has_source, done_q, $past(start) || $past(busy), "result without an item")
	// The solved flag can only come out of a completed full board check.
	`MCQ_ASSERT_IMP(a_solved_after_check, done_q && result_q.solved, $past(state_q == S_CHK_FLUSH), "solved without check")
	// A moved queen is reported only after its counts were updated.
	`MCQ_ASSERT_IMP(a_moved_after_place, done_q && result_q.moved, $past(state_q == S_PLACE_WR) || $past(state_q == S_CHK_FLUSH), "moved without update")
	// During the scan the best score never rises.
	`MCQ_ASSERT(a_score_never_rises, state_q == S_AD_SCAN && cmp_v_s1 |=> best_score_q <= $past(best_score_q), "best score rose")

endmodule
